### sv/ple_pkg.sv
package ple_pkg;

  localparam int unsigned DepthDefault    = 64;
  localparam int unsigned KeyWidthDefault = 32;
  // cells examined per scan cycle for read and find
  localparam int unsigned ScanLanes       = 8;

  localparam logic [2:0] OP_INSERT = 3'd0;
  localparam logic [2:0] OP_REMOVE = 3'd1;
  localparam logic [2:0] OP_READ   = 3'd2;
  localparam logic [2:0] OP_WRITE  = 3'd3;
  localparam logic [2:0] OP_FIND   = 3'd4;

  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_FULL   = 2'd1;
  localparam logic [1:0] ST_BADPOS = 2'd2;
  localparam logic [1:0] ST_NOKEY  = 2'd3;

  typedef struct packed {
    logic [2:0]  opcode;
    logic [6:0]  position;
    logic [31:0] entry_key;
    logic [31:0] entry_payload;
  } in_item_t;

  typedef struct packed {
    logic [31:0] out_key;
    logic [31:0] out_payload;
    logic [6:0]  found_position;
    logic [6:0]  entry_count;
    logic [1:0]  status;
  } out_item_t;

  typedef struct packed {
    logic [31:0] key;
    logic [31:0] payload;
  } rec_t;

  typedef struct packed {
    logic hit;
    rec_t rec;
  } tap_t;

  typedef enum logic [2:0] {
    CELL_HOLD,
    CELL_INSERT,
    CELL_REMOVE,
    CELL_WRITE,
    CELL_LOAD,
    CELL_SHIFT
  } cell_op_t;

  typedef struct packed {
    cell_op_t op;
    logic     find;
  } cell_ctl_t;

endpackage

### sv/ple_cell.sv
module ple_cell #(
  parameter int unsigned DEPTH = 64,
  parameter int unsigned IDX   = 0
) (
  input  logic                         clk,
  input  ple_pkg::cell_ctl_t           ctl,
  input  logic [$clog2(DEPTH)-1:0]     pos0,
  input  logic [$clog2(DEPTH+1)-1:0]   cnt,
  input  ple_pkg::rec_t                new_rec,
  input  ple_pkg::rec_t                prev_rec,
  input  ple_pkg::rec_t                next_rec,
  input  ple_pkg::tap_t                far_tap,
  output ple_pkg::rec_t                rec,
  output ple_pkg::tap_t                tap
);
  import ple_pkg::*;

  localparam int unsigned IW = $clog2(DEPTH);
  localparam int unsigned CW = $clog2(DEPTH+1);

  rec_t rec_r, rec_nxt;
  tap_t tap_r, tap_nxt;
  logic here, above, in_use;

  assign here   = (IW'(IDX) == pos0);
  assign above  = (IW'(IDX) > pos0);
  assign in_use = (CW'(IDX) < cnt);

  always_comb begin
    rec_nxt = rec_r;
    tap_nxt = tap_r;
    case (ctl.op)
      CELL_INSERT: begin
        if (above) begin
          rec_nxt = prev_rec;
        end else if (here) begin
          rec_nxt = new_rec;
        end
      end
      CELL_REMOVE: begin
        if (here || above) begin
          rec_nxt = next_rec;
        end
      end
      CELL_WRITE: begin
        if (here) begin
          rec_nxt = new_rec;
        end
      end
      CELL_LOAD: begin
        tap_nxt.hit = in_use && (ctl.find ? (rec_r.key == new_rec.key) : here);
        tap_nxt.rec = rec_r;
      end
      CELL_SHIFT: begin
        tap_nxt = far_tap;
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    rec_r <= rec_nxt;
    tap_r <= tap_nxt;
  end

  assign rec = rec_r;
  assign tap = tap_r;

endmodule

### sv/ple_pick.sv
module ple_pick #(
  parameter int unsigned LANES = 8
) (
  input  ple_pkg::tap_t [LANES-1:0]                    lanes,
  output logic                                         hit,
  output logic [((LANES > 1) ? $clog2(LANES) : 1)-1:0] lane,
  output ple_pkg::rec_t                                rec
);
  import ple_pkg::*;

  localparam int unsigned LW = (LANES > 1) ? $clog2(LANES) : 1;

  // lowest lane wins: walk down so the last hit assigned is the lowest
  always_comb begin
    hit  = 1'b0;
    lane = '0;
    rec  = '0;
    for (int k = LANES - 1; k >= 0; k--) begin
      if (lanes[k].hit) begin
        hit  = 1'b1;
        lane = LW'(k);
        rec  = lanes[k].rec;
      end
    end
  end

endmodule

### sv/positional_list_engine.sv
// Channel  Direction  Handshake              Payload
// in_      input      in_valid / in_stall    ple_pkg::in_item_t   (opcode, position, key, payload)
// out_     output     out_valid / out_stall  ple_pkg::out_item_t  (record, match, count, status)
//
// Insert, remove, overwrite, rejected items and unknown opcodes finish in the
// accept cycle; their result is in the output register on the next cycle.
// Read and find load the tap row, then scan it as the row shifts 8 cells a cycle down
// the chain; a read stops at the selected cell, a find at the first matching key or the end of the list.
// The next item is taken once the engine is idle and the result register is
// free or being emptied. Reset (rst_n low, synchronous) empties the list.
module positional_list_engine #(
  parameter int unsigned DEPTH     = ple_pkg::DepthDefault,
  parameter int unsigned KEY_WIDTH = ple_pkg::KeyWidthDefault
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  ple_pkg::in_item_t  in_data,
  output logic               out_valid,
  input  logic               out_stall,
  output ple_pkg::out_item_t out_data
);
  import ple_pkg::*;

  localparam int unsigned IW    = $clog2(DEPTH);
  localparam int unsigned CW    = $clog2(DEPTH+1);
  localparam int unsigned SW    = CW + 8;
  localparam int unsigned LANES = (DEPTH < ScanLanes) ? DEPTH : ScanLanes;
  localparam int unsigned LW    = (LANES > 1) ? $clog2(LANES) : 1;
  localparam logic [31:0] KeyMask = 32'((64'd1 << KEY_WIDTH) - 64'd1);

  typedef enum logic [0:0] {S_IDLE, S_SCAN} state_t;

  state_t    state_r, state_nxt;
  logic [CW-1:0] count_r, count_nxt;
  logic [CW-1:0] base_r, base_nxt;
  logic      is_find_r, is_find_nxt;
  logic      out_valid_r, out_valid_nxt;
  out_item_t out_data_r, out_data_nxt;

  cell_ctl_t ctl;
  logic [IW-1:0] pos0;
  rec_t      new_rec;
  logic      acc;
  logic      full, ins_ok, pos_ok, last;
  logic [SW-1:0] pos_ext, cnt_ext, base_ext;

  rec_t cell_rec [DEPTH];
  tap_t cell_tap [DEPTH];
  tap_t [LANES-1:0] lane_taps;

  logic          pick_hit;
  logic [LW-1:0] pick_lane;
  rec_t          pick_rec;

  // Row of cells: each holds one record and one scan tap.
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    rec_t prev_w, next_w;
    tap_t far_w;
    if (i == 0) begin : g_first
      assign prev_w = cell_rec[0];
    end else begin : g_mid
      assign prev_w = cell_rec[i-1];
    end
    if (i == DEPTH - 1) begin : g_last
      assign next_w = cell_rec[i];
    end else begin : g_inner
      assign next_w = cell_rec[i+1];
    end
    if (i + LANES >= DEPTH) begin : g_far_end
      assign far_w = '0;
    end else begin : g_far
      assign far_w = cell_tap[i+LANES];
    end
    ple_cell #(.DEPTH(DEPTH), .IDX(i)) u_cell (
      .clk      (clk),
      .ctl      (ctl),
      .pos0     (pos0),
      .cnt      (count_r),
      .new_rec  (new_rec),
      .prev_rec (prev_w),
      .next_rec (next_w),
      .far_tap  (far_w),
      .rec      (cell_rec[i]),
      .tap      (cell_tap[i])
    );
  end

  for (genvar k = 0; k < LANES; k++) begin : g_lane
    assign lane_taps[k] = cell_tap[k];
  end

  // First hit among the low cells of the tap row.
  ple_pick #(.LANES(LANES)) u_pick (
    .lanes (lane_taps),
    .hit   (pick_hit),
    .lane  (pick_lane),
    .rec   (pick_rec)
  );

  assign in_stall = (state_r != S_IDLE) || (out_valid_r && out_stall);
  assign acc      = in_valid && !in_stall;

  // Keys are kept masked to KEY_WIDTH so stored and searched keys compare alike.
  assign new_rec.key     = in_data.entry_key & KeyMask;
  assign new_rec.payload = in_data.entry_payload;

  assign pos_ext  = SW'(in_data.position);
  assign cnt_ext  = SW'(count_r);
  assign base_ext = SW'(base_r);
  assign pos0     = IW'(pos_ext - SW'(1));
  assign full     = (count_r == CW'(DEPTH));
  assign ins_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext + SW'(1));
  assign pos_ok   = (pos_ext != '0) && (pos_ext <= cnt_ext);
  assign last     = (base_ext + SW'(LANES) >= cnt_ext);

  always_comb begin
    state_nxt     = state_r;
    count_nxt     = count_r;
    base_nxt      = base_r;
    is_find_nxt   = is_find_r;
    out_valid_nxt = out_valid_r && out_stall;
    out_data_nxt  = out_data_r;
    ctl.op        = CELL_HOLD;
    ctl.find      = 1'b0;

    case (state_r)
      S_IDLE: begin
        if (acc) begin
          // default: result goes to the output register with zeroed record fields
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.status = ST_OK;
          case (in_data.opcode)
            OP_INSERT: begin
              if (full) begin
                out_data_nxt.status = ST_FULL;
              end else if (!ins_ok) begin
                out_data_nxt.status = ST_BADPOS;
              end else begin
                ctl.op    = CELL_INSERT;
                count_nxt = count_r + CW'(1);
              end
            end
            OP_REMOVE: begin
              if (!pos_ok) begin
                out_data_nxt.status = ST_BADPOS;
              end else begin
                ctl.op    = CELL_REMOVE;
                count_nxt = count_r - CW'(1);
              end
            end
            OP_WRITE: begin
              if (!pos_ok) begin
                out_data_nxt.status = ST_BADPOS;
              end else begin
                ctl.op = CELL_WRITE;
              end
            end
            OP_READ: begin
              if (!pos_ok) begin
                out_data_nxt.status = ST_BADPOS;
              end else begin
                // load taps, then scan for the selected cell
                ctl.op        = CELL_LOAD;
                out_valid_nxt = 1'b0;
                is_find_nxt   = 1'b0;
                base_nxt      = '0;
                state_nxt     = S_SCAN;
              end
            end
            OP_FIND: begin
              ctl.op        = CELL_LOAD;
              ctl.find      = 1'b1;
              out_valid_nxt = 1'b0;
              is_find_nxt   = 1'b1;
              base_nxt      = '0;
              state_nxt     = S_SCAN;
            end
            default: begin
            end
          endcase
          out_data_nxt.entry_count = 7'(count_nxt);
        end
      end
      S_SCAN: begin
        if (pick_hit || last) begin
          out_valid_nxt = 1'b1;
          out_data_nxt  = '0;
          out_data_nxt.entry_count = 7'(count_r);
          state_nxt     = S_IDLE;
          if (is_find_r) begin
            if (pick_hit) begin
              out_data_nxt.found_position = 7'(base_ext + SW'(pick_lane) + SW'(1));
              out_data_nxt.status         = ST_OK;
            end else begin
              out_data_nxt.status = ST_NOKEY;
            end
          end else begin
            out_data_nxt.out_key     = pick_rec.key;
            out_data_nxt.out_payload = pick_rec.payload;
            out_data_nxt.status      = ST_OK;
          end
        end else begin
          // advance the tap window by one group
          ctl.op   = CELL_SHIFT;
          base_nxt = base_r + CW'(LANES);
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      count_r     <= '0;
      base_r      <= '0;
      is_find_r   <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      count_r     <= count_nxt;
      base_r      <= base_nxt;
      is_find_r   <= is_find_nxt;
      out_valid_r <= out_valid_nxt;
    end
    out_data_r <= out_data_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### verif/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import ple_pkg::*;

  localparam int LIST_DEPTH = DepthDefault;
  // Hard stop for a hung run
  localparam int CYCLE_LIMIT = 400000;
  // Settling time after the drain; covers a full read or find scan after its load
  localparam int SETTLE_CYCLES = 40;
  localparam int ITEMS_PER_PHASE = 200;

  // Opcodes that the block ignores
  localparam logic [2:0] OP_SPARE_5 = 3'd5;
  localparam logic [2:0] OP_SPARE_6 = 3'd6;
  localparam logic [2:0] OP_SPARE_7 = 3'd7;

  logic      clk = 1'b0;
  logic      rst_n = 1'b0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  in_item_t  in_data = '0;
  logic      out_valid;
  logic      out_stall = 1'b0;
  out_item_t out_data;

  positional_list_engine DUT (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .out_data (out_data)
  );

  initial begin
    forever #4 clk = ~clk;
  end

  // Shadow copy of the list: records in position order, plus the record count
  rec_t        list_rec [LIST_DEPTH];
  int          list_count = 0;
  out_item_t   pending_results[$];

  int          errors = 0;
  int          items_sent = 0;
  int          results_seen = 0;
  int          full_rejects = 0;
  int          peak_count = 0;
  int          cycle_count = 0;
  int          sender_gap_pct = 0;
  int          recv_stall_pct = 0;
  bit          draining = 1'b0;
  logic [31:0] key_pool [8];

  // Directed rows: the expected result is typed in where it is obvious, otherwise the
  // predictor supplies it.
  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } directed_row_t;

  localparam directed_row_t DIRECTED [0:24] = '{
    // Empty list: every positional access is a bad position, find misses
    '{'{OP_READ,   7'd1,   32'h0, 32'h0}, 1'b1, '{32'h0, 32'h0, 7'd0, 7'd0, ST_BADPOS}},
    '{'{OP_REMOVE, 7'd1,   32'h0, 32'h0}, 1'b1, '{32'h0, 32'h0, 7'd0, 7'd0, ST_BADPOS}},
    '{'{OP_WRITE,  7'd1,   32'h1, 32'h1}, 1'b1, '{32'h0, 32'h0, 7'd0, 7'd0, ST_BADPOS}},
    '{'{OP_FIND,   7'd0,   32'h0, 32'h0}, 1'b1, '{32'h0, 32'h0, 7'd0, 7'd0, ST_NOKEY}},
    // Insert outside 1..count+1
    '{'{OP_INSERT, 7'd0,   32'h1, 32'h1}, 1'b1, '{32'h0, 32'h0, 7'd0, 7'd0, ST_BADPOS}},
    '{'{OP_INSERT, 7'd2,   32'h1, 32'h1}, 1'b1, '{32'h0, 32'h0, 7'd0, 7'd0, ST_BADPOS}},
    // Build [0, all-ones, 12345678]: insert at front, then append
    '{'{OP_INSERT, 7'd1, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
      '{32'h0, 32'h0, 7'd0, 7'd1, ST_OK}},
    '{'{OP_INSERT, 7'd1, 32'h0, 32'h0}, 1'b1, '{32'h0, 32'h0, 7'd0, 7'd2, ST_OK}},
    '{'{OP_INSERT, 7'd3, 32'h1234_5678, 32'hA5A5_A5A5}, 1'b1,
      '{32'h0, 32'h0, 7'd0, 7'd3, ST_OK}},
    '{'{OP_READ,   7'd1,   32'h0, 32'h0}, 1'b1, '{32'h0, 32'h0, 7'd0, 7'd3, ST_OK}},
    '{'{OP_READ,   7'd2,   32'h0, 32'h0}, 1'b1,
      '{32'hFFFF_FFFF, 32'hFFFF_FFFF, 7'd0, 7'd3, ST_OK}},
    '{'{OP_FIND, 7'd0, 32'hFFFF_FFFF, 32'h0}, 1'b1, '{32'h0, 32'h0, 7'd2, 7'd3, ST_OK}},
    '{'{OP_FIND, 7'd0, 32'hDEAD_BEEF, 32'h0}, 1'b1, '{32'h0, 32'h0, 7'd0, 7'd3, ST_NOKEY}},
    '{'{OP_WRITE, 7'd3, 32'h5A5A_5A5A, 32'h8000_0001}, 1'b1,
      '{32'h0, 32'h0, 7'd0, 7'd3, ST_OK}},
    '{'{OP_READ,   7'd3,   32'h0, 32'h0}, 1'b0, '0},
    '{'{OP_WRITE,  7'd4,   32'h7, 32'h7}, 1'b1, '{32'h0, 32'h0, 7'd0, 7'd3, ST_BADPOS}},
    '{'{OP_READ,   7'd127, 32'h0, 32'h0}, 1'b1, '{32'h0, 32'h0, 7'd0, 7'd3, ST_BADPOS}},
    '{'{OP_INSERT, 7'd5,   32'h0, 32'h0}, 1'b1, '{32'h0, 32'h0, 7'd0, 7'd3, ST_BADPOS}},
    // Unused opcodes: no effect, only the count comes back
    '{'{OP_SPARE_5, 7'd127, 32'hFFFF_FFFF, 32'hFFFF_FFFF}, 1'b1,
      '{32'h0, 32'h0, 7'd0, 7'd3, ST_OK}},
    '{'{OP_SPARE_6, 7'd64, 32'h1234_5678, 32'h0}, 1'b1, '{32'h0, 32'h0, 7'd0, 7'd3, ST_OK}},
    '{'{OP_SPARE_7, 7'd65, 32'h0, 32'hFFFF_FFFF}, 1'b1, '{32'h0, 32'h0, 7'd0, 7'd3, ST_OK}},
    // Remove from the front, past the end, then from the back
    '{'{OP_REMOVE, 7'd1,   32'h0, 32'h0}, 1'b1, '{32'h0, 32'h0, 7'd0, 7'd2, ST_OK}},
    '{'{OP_REMOVE, 7'd3,   32'h0, 32'h0}, 1'b1, '{32'h0, 32'h0, 7'd0, 7'd2, ST_BADPOS}},
    '{'{OP_FIND,   7'd0,   32'h0, 32'h0}, 1'b0, '0},
    '{'{OP_REMOVE, 7'd2,   32'h0, 32'h0}, 1'b0, '0}
  };

  // Apply one operation to the shadow list and return the result the block owes for it.
  function automatic out_item_t apply_list_op(in_item_t it);
    out_item_t res;
    int        pos;
    int        j;
    res = '0;
    pos = it.position;
    res.status = ST_OK;
    case (it.opcode)
      OP_INSERT: begin
        // Full is checked before the position
        if (list_count >= LIST_DEPTH) begin
          res.status = ST_FULL;
        end else if (pos < 1 || pos > list_count + 1) begin
          res.status = ST_BADPOS;
        end else begin
          for (j = list_count; j > pos - 1; j--) list_rec[j] = list_rec[j - 1];
          list_rec[pos - 1] = {it.entry_key, it.entry_payload};
          list_count++;
        end
      end
      OP_REMOVE, OP_READ, OP_WRITE: begin
        if (pos < 1 || pos > list_count) begin
          res.status = ST_BADPOS;
        end else if (it.opcode == OP_REMOVE) begin
          for (j = pos - 1; j + 1 < list_count; j++) list_rec[j] = list_rec[j + 1];
          list_count--;
        end else if (it.opcode == OP_READ) begin
          res.out_key     = list_rec[pos - 1].key;
          res.out_payload = list_rec[pos - 1].payload;
        end else begin
          list_rec[pos - 1] = {it.entry_key, it.entry_payload};
        end
      end
      OP_FIND: begin
        res.status = ST_NOKEY;
        for (j = 0; j < list_count; j++) begin
          if (list_rec[j].key == it.entry_key) begin
            res.found_position = 7'(j + 1);
            res.status = ST_OK;
            break;
          end
        end
      end
      default: ;
    endcase
    res.entry_count = 7'(list_count);
    return res;
  endfunction

  // Mostly well-formed traffic that fills the list to the top and drains it again;
  // a small share is raw noise over every field value.
  function automatic in_item_t next_random_item();
    in_item_t it;
    int       roll;
    int       cnt;
    cnt = list_count;
    if (!draining && cnt == LIST_DEPTH && $urandom_range(0, 3) == 0) draining = 1'b1;
    if (draining && cnt == 0) draining = 1'b0;
    it.entry_key     = ($urandom_range(0, 9) < 3) ? $urandom : key_pool[$urandom_range(0, 7)];
    it.entry_payload = $urandom;
    if ($urandom_range(0, 99) < 8) begin
      it.opcode   = 3'($urandom_range(0, 7));
      it.position = 7'($urandom_range(0, 127));
      return it;
    end
    roll = $urandom_range(0, 99);
    if (roll < (draining ? 10 : 50)) it.opcode = OP_INSERT;
    else if (roll < 60)               it.opcode = OP_REMOVE;
    else if (roll < 75)               it.opcode = OP_READ;
    else if (roll < 85)               it.opcode = OP_WRITE;
    else                              it.opcode = OP_FIND;
    if (it.opcode == OP_INSERT) begin
      it.position = 7'($urandom_range(1, cnt + 1));
    end else if (it.opcode == OP_FIND) begin
      it.position = 7'($urandom_range(0, 127));
      // Search for a key that is held most of the time
      if (cnt > 0 && $urandom_range(0, 3) != 0) begin
        it.entry_key = list_rec[$urandom_range(0, cnt - 1)].key;
      end
    end else begin
      it.position = (cnt == 0) ? 7'd1 : 7'($urandom_range(1, cnt));
    end
    // Push an occasional position just past the valid range
    if (it.opcode != OP_FIND && $urandom_range(0, 19) == 0) it.position = 7'(cnt + 2);
    return it;
  endfunction

  // Offer one item, hold it through stalls, and log its expectation once taken.
  task automatic send_item(input in_item_t it, input logic typed, input out_item_t want);
    out_item_t predicted;
    // Idle the sender a random number of cycles
    while ($urandom_range(0, 99) < sender_gap_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data  <= it;
    do @(posedge clk); while (in_stall);
    predicted = apply_list_op(it);
    pending_results.push_back(typed ? want : predicted);
    items_sent++;
    if (predicted.status == ST_FULL) full_rejects++;
    if (list_count > peak_count) peak_count = list_count;
  endtask

  task automatic check_field(input string name, input logic [31:0] want, input logic [31:0] got);
    if (want !== got) begin
      errors++;
      $display("%0t: %s mismatch: expected %h, got %h", $time, name, want, got);
    end
  endtask

  // Stimulus: reset, directed table, then three random phases with different idling
  initial begin : stimulus
    int phase;
    foreach (key_pool[i]) key_pool[i] = $urandom;
    key_pool[0] = '0;
    key_pool[1] = '1;
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;

    foreach (DIRECTED[i]) send_item(DIRECTED[i].item, DIRECTED[i].typed, DIRECTED[i].want);

    for (phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin sender_gap_pct = 14; recv_stall_pct = 50; end
        1:       begin sender_gap_pct = 50; recv_stall_pct = 14; end
        default: begin sender_gap_pct = 0;  recv_stall_pct = 0;  end
      endcase
      repeat (ITEMS_PER_PHASE) send_item(next_random_item(), 1'b0, '0);
    end
    in_valid <= 1'b0;

    // Drain: wait for every owed result, then let the engine settle
    while (pending_results.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);

    $display("Sent %0d items and checked %0d results; list peaked at %0d records,",
             items_sent, results_seen, peak_count);
    $display("with %0d inserts refused on a full list.", full_rejects);
    if (errors == 0) begin
      $display("positional_list_engine regression: pass");
    end else begin
      $display("positional_list_engine regression: fail");
    end
    $finish;
  end

  // Receiver: stall at random at the rate of the current phase
  always @(posedge clk) begin
    out_stall <= rst_n && ($urandom_range(0, 99) < recv_stall_pct);
  end

  // Compare each taken result with the oldest expectation
  always @(posedge clk) begin : result_check
    out_item_t want;
    if (rst_n && out_valid && !out_stall) begin
      results_seen++;
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result with none expected: got %h", $time, out_data);
      end else begin
        want = pending_results.pop_front();
        check_field("out_key", want.out_key, out_data.out_key);
        check_field("out_payload", want.out_payload, out_data.out_payload);
        check_field("found_position", 32'(want.found_position), 32'(out_data.found_position));
        check_field("entry_count", 32'(want.entry_count), 32'(out_data.entry_count));
        check_field("status", 32'(want.status), 32'(out_data.status));
      end
    end
  end

  // Watchdog: abandon a hung run
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles with %0d results outstanding",
               cycle_count, pending_results.size());
      $display("positional_list_engine regression: fail");
      $finish;
    end
  end

endmodule

### positional_list_engine.f
sv/ple_pkg.sv
sv/ple_cell.sv
sv/ple_pick.sv
sv/positional_list_engine.sv
verif/tb.sv
